>>> design/dwsc_pkg.sv
// shared types and constants of the dual wheel speed controller
package dwsc_pkg;

  // kind of an input transaction
  typedef enum logic [1:0] {
    REQ_TICK    = 2'd0,
    REQ_SET     = 2'd1,
    REQ_STOP    = 2'd2,
    REQ_CONTROL = 2'd3
  } req_type_t;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_GAIN_P       = 3'd0,
    REG_GAIN_D       = 3'd1,
    REG_DRIVE_LIMIT  = 3'd2,
    REG_SLEW_STEP    = 3'd3,
    REG_SPEED_LIMIT  = 3'd4,
    REG_LEASE_LENGTH = 3'd5
  } reg_index_t;

  localparam logic ACK_OK     = 1'b0;
  localparam logic ACK_REJECT = 1'b1;

  localparam logic [21:0] GAIN_P_RESET       = 22'd458752;
  localparam logic [15:0] GAIN_D_RESET       = 16'd197;
  localparam logic [15:0] DRIVE_LIMIT_RESET  = 16'd7199;
  localparam logic [7:0]  SLEW_STEP_RESET    = 8'd20;
  localparam logic [14:0] SPEED_LIMIT_RESET  = 15'd420;
  localparam logic [15:0] LEASE_LENGTH_RESET = 16'd300;

  localparam logic [15:0] ELAPSED_MAX = 16'hFFFF;

  // settings shared by both wheel loops
  typedef struct packed {
    logic [21:0] gain_p;
    logic [15:0] gain_d;
    logic [15:0] drive_limit;
    logic [7:0]  slew_step;
  } wheel_cfg_t;

endpackage

>>> design/dwsc_wheel.sv
// per-wheel ramp slew and incremental pd step with drive saturation
module dwsc_wheel (
  input  dwsc_pkg::wheel_cfg_t cfg,
  input  logic signed [15:0]   target,
  input  logic signed [15:0]   ramp,
  input  logic signed [15:0]   count,
  input  logic signed [16:0]   accum,
  input  logic signed [17:0]   last_err,
  output logic signed [15:0]   ramp_next,
  output logic signed [16:0]   accum_next,
  output logic signed [17:0]   last_err_next
);
  import dwsc_pkg::*;

  logic signed [16:0] ramp_up;
  logic signed [16:0] ramp_dn;
  logic signed [16:0] target_x;
  logic signed [16:0] err;
  logic signed [18:0] derr;
  logic signed [40:0] prod_p;
  logic signed [40:0] prod_d;
  logic signed [40:0] sum;
  logic signed [40:0] biased;
  logic signed [24:0] quo;
  logic signed [25:0] acc_sum;
  logic signed [25:0] lim;

  // slew toward the target by at most one step
  always_comb begin
    target_x = 17'(target);
    ramp_up  = 17'(ramp) + $signed({9'b0, cfg.slew_step});
    ramp_dn  = 17'(ramp) - $signed({9'b0, cfg.slew_step});
    if (ramp < target) begin
      ramp_next = (ramp_up > target_x) ? target : ramp_up[15:0];
    end else if (ramp > target) begin
      ramp_next = (ramp_dn < target_x) ? target : ramp_dn[15:0];
    end else begin
      ramp_next = ramp;
    end
  end

  // q16 pd sum, truncated toward zero, then clamped
  always_comb begin
    err     = 17'(ramp_next) - 17'(count);
    derr    = 19'(err) - 19'(last_err);
    prod_p  = 41'($signed({1'b0, cfg.gain_p})) * 41'(err);
    prod_d  = 41'($signed({1'b0, cfg.gain_d})) * 41'(derr);
    sum     = prod_p + prod_d;
    biased  = sum + (sum[40] ? 41'sd65535 : 41'sd0);
    quo     = biased[40:16];
    acc_sum = 26'(accum) + 26'(quo);
    lim     = $signed({10'b0, cfg.drive_limit});
    if (acc_sum > lim) begin
      accum_next = lim[16:0];
    end else if (acc_sum < -lim) begin
      accum_next = 17'(-lim);
    end else begin
      accum_next = acc_sum[16:0];
    end
    last_err_next = 18'(err);
  end

endmodule

>>> design/dual_wheel_speed_controller_top.sv
// top level of the dual wheel speed controller
//
//  channel   direction  handshake           payload
//  s_*       in         s_tvalid/s_tready   tuser req_type, tdata counts and speeds
//  m_*       out        m_tvalid/m_tready   tuser ack_code, tdata drives, lease, odometers
//  cfg_*     in         cfg_valid/cfg_ready cfg_index register, cfg_data value
//
// one transaction per cycle sustained while m_tready stays high; an accepted
// transaction loads the input register, and its result then loads the result
// register; the pd math for both wheels is combinational between the two registers
// rst is synchronous; it restores the register defaults and clears all state
// a stalled result holds in the result register while the next input waits
// in the input register; cfg_ready is always high
module dual_wheel_speed_controller_top (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [1:0]   s_tuser,   // req_type
  input  logic [63:0]  s_tdata,   // count_left, count_right, cmd_speed_l, cmd_speed_r
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic         m_tuser,   // ack_code
  output logic [103:0] m_tdata,   // drive_left, drive_right, lease_on, odometer_left,
                                  // odometer_right, zero fill
  input  logic         cfg_valid,
  output logic         cfg_ready,
  input  logic [2:0]   cfg_index,
  input  logic [31:0]  cfg_data
);
  import dwsc_pkg::*;

  // configuration registers
  logic [21:0] gain_p;
  logic [15:0] gain_d;
  logic [15:0] drive_limit;
  logic [7:0]  slew_step;
  logic [14:0] speed_limit;
  logic [15:0] lease_length;

  // input register
  logic               in_valid;
  req_type_t          in_type;
  logic signed [15:0] in_count_l;
  logic signed [15:0] in_count_r;
  logic signed [15:0] in_speed_l;
  logic signed [15:0] in_speed_r;

  // controller state
  logic signed [15:0] target_l, target_r, ramp_l, ramp_r;
  logic signed [16:0] accum_l, accum_r;
  logic signed [17:0] last_err_l, last_err_r;
  logic [31:0]        odo_l, odo_r;
  logic               lease_active;
  logic [15:0]        lease_elapsed;

  logic signed [15:0] target_l_next, target_r_next, ramp_l_next, ramp_r_next;
  logic signed [16:0] accum_l_next, accum_r_next;
  logic signed [17:0] last_err_l_next, last_err_r_next;
  logic [31:0]        odo_l_next, odo_r_next;
  logic               lease_active_next;
  logic [15:0]        lease_elapsed_next;
  logic               ack_next;

  // wheel unit results
  logic signed [15:0] wl_ramp, wr_ramp;
  logic signed [16:0] wl_accum, wr_accum;
  logic signed [17:0] wl_err, wr_err;

  // result register
  logic               out_valid;
  logic signed [16:0] out_drive_l, out_drive_r;
  logic               out_ack;
  logic               out_lease;
  logic [31:0]        out_odo_l, out_odo_r;

  logic               advance;
  logic [15:0]        elapsed_inc;
  logic signed [16:0] speed_lim_x;
  logic               speed_ok;
  wheel_cfg_t         wheel_cfg;

  assign advance   = in_valid && (!out_valid || m_tready);
  assign s_tready  = !in_valid || advance;
  assign cfg_ready = 1'b1;

  // configuration writes, unknown indexes are dropped
  always_ff @(posedge clk) begin
    if (rst) begin
      gain_p       <= GAIN_P_RESET;
      gain_d       <= GAIN_D_RESET;
      drive_limit  <= DRIVE_LIMIT_RESET;
      slew_step    <= SLEW_STEP_RESET;
      speed_limit  <= SPEED_LIMIT_RESET;
      lease_length <= LEASE_LENGTH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_GAIN_P:       gain_p       <= cfg_data[21:0];
        REG_GAIN_D:       gain_d       <= cfg_data[15:0];
        REG_DRIVE_LIMIT:  drive_limit  <= cfg_data[15:0];
        REG_SLEW_STEP:    slew_step    <= cfg_data[7:0];
        REG_SPEED_LIMIT:  speed_limit  <= cfg_data[14:0];
        REG_LEASE_LENGTH: lease_length <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      in_type    <= req_type_t'(s_tuser);
      in_count_l <= s_tdata[15:0];
      in_count_r <= s_tdata[31:16];
      in_speed_l <= s_tdata[47:32];
      in_speed_r <= s_tdata[63:48];
    end
  end

  assign wheel_cfg = '{gain_p: gain_p, gain_d: gain_d,
                       drive_limit: drive_limit, slew_step: slew_step};

  dwsc_wheel u_wheel_l (
    .cfg           (wheel_cfg),
    .target        (target_l),
    .ramp          (ramp_l),
    .count         (in_count_l),
    .accum         (accum_l),
    .last_err      (last_err_l),
    .ramp_next     (wl_ramp),
    .accum_next    (wl_accum),
    .last_err_next (wl_err)
  );

  dwsc_wheel u_wheel_r (
    .cfg           (wheel_cfg),
    .target        (target_r),
    .ramp          (ramp_r),
    .count         (in_count_r),
    .accum         (accum_r),
    .last_err      (last_err_r),
    .ramp_next     (wr_ramp),
    .accum_next    (wr_accum),
    .last_err_next (wr_err)
  );

  assign elapsed_inc = (lease_elapsed == ELAPSED_MAX) ? lease_elapsed : lease_elapsed + 16'd1;
  assign speed_lim_x = $signed({2'b0, speed_limit});
  assign speed_ok    = (17'(in_speed_l) >= -speed_lim_x) && (17'(in_speed_l) <= speed_lim_x) &&
                       (17'(in_speed_r) >= -speed_lim_x) && (17'(in_speed_r) <= speed_lim_x);

  // next state for the item in the input register
  always_comb begin
    target_l_next      = target_l;
    target_r_next      = target_r;
    ramp_l_next        = ramp_l;
    ramp_r_next        = ramp_r;
    accum_l_next       = accum_l;
    accum_r_next       = accum_r;
    last_err_l_next    = last_err_l;
    last_err_r_next    = last_err_r;
    odo_l_next         = odo_l;
    odo_r_next         = odo_r;
    lease_active_next  = lease_active;
    lease_elapsed_next = lease_elapsed;
    ack_next           = ACK_OK;
    case (in_type)
      REQ_TICK: begin
        if (lease_active) begin
          if (elapsed_inc >= lease_length) begin
            // lease expired: same as stop
            target_l_next      = '0;
            target_r_next      = '0;
            ramp_l_next        = '0;
            ramp_r_next        = '0;
            accum_l_next       = '0;
            accum_r_next       = '0;
            last_err_l_next    = '0;
            last_err_r_next    = '0;
            lease_active_next  = 1'b0;
            lease_elapsed_next = '0;
          end else begin
            lease_elapsed_next = elapsed_inc;
          end
        end
      end
      REQ_SET: begin
        if (speed_ok) begin
          target_l_next      = in_speed_l;
          target_r_next      = in_speed_r;
          lease_elapsed_next = '0;
          lease_active_next  = 1'b1;
        end else begin
          ack_next = ACK_REJECT;
        end
      end
      REQ_STOP: begin
        target_l_next      = '0;
        target_r_next      = '0;
        ramp_l_next        = '0;
        ramp_r_next        = '0;
        accum_l_next       = '0;
        accum_r_next       = '0;
        last_err_l_next    = '0;
        last_err_r_next    = '0;
        lease_active_next  = 1'b0;
        lease_elapsed_next = '0;
      end
      REQ_CONTROL: begin
        odo_l_next  = odo_l + 32'(in_count_l);
        odo_r_next  = odo_r + 32'(in_count_r);
        ramp_l_next = wl_ramp;
        ramp_r_next = wr_ramp;
        // pd state only moves while the lease holds
        if (lease_active) begin
          accum_l_next    = wl_accum;
          accum_r_next    = wr_accum;
          last_err_l_next = wl_err;
          last_err_r_next = wr_err;
        end
      end
      default: ;
    endcase
  end

  // state update
  always_ff @(posedge clk) begin
    if (rst) begin
      target_l      <= '0;
      target_r      <= '0;
      ramp_l        <= '0;
      ramp_r        <= '0;
      accum_l       <= '0;
      accum_r       <= '0;
      last_err_l    <= '0;
      last_err_r    <= '0;
      odo_l         <= '0;
      odo_r         <= '0;
      lease_active  <= 1'b0;
      lease_elapsed <= '0;
    end else if (advance) begin
      target_l      <= target_l_next;
      target_r      <= target_r_next;
      ramp_l        <= ramp_l_next;
      ramp_r        <= ramp_r_next;
      accum_l       <= accum_l_next;
      accum_r       <= accum_r_next;
      last_err_l    <= last_err_l_next;
      last_err_r    <= last_err_r_next;
      odo_l         <= odo_l_next;
      odo_r         <= odo_r_next;
      lease_active  <= lease_active_next;
      lease_elapsed <= lease_elapsed_next;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (m_tready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_drive_l <= lease_active_next ? accum_l_next : 17'sd0;
      out_drive_r <= lease_active_next ? accum_r_next : 17'sd0;
      out_ack     <= ack_next;
      out_lease   <= lease_active_next;
      out_odo_l   <= odo_l_next;
      out_odo_r   <= odo_r_next;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tuser  = out_ack;
  assign m_tdata  = {5'b0, out_odo_r, out_odo_l, out_lease, out_drive_r, out_drive_l};

`ifndef SYNTHESIS
  // drive is forced to zero whenever the lease is off
  a_drive_zero_inactive: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_lease) |-> (out_drive_l == 17'sd0 && out_drive_r == 17'sd0))
    else $error("nonzero drive without lease");

  // with no lease all motion state sits at zero
  a_idle_state_clear: assert property (@(posedge clk) disable iff (rst)
    !lease_active |-> (target_l == 16'sd0 && target_r == 16'sd0 &&
                       ramp_l == 16'sd0 && ramp_r == 16'sd0 &&
                       accum_l == 17'sd0 && accum_r == 17'sd0 &&
                       last_err_l == 18'sd0 && last_err_r == 18'sd0))
    else $error("motion state left over while lease is off");

  // a stop always ends the lease
  a_stop_ends_lease: assert property (@(posedge clk) disable iff (rst)
    (advance && in_type == REQ_STOP) |=> (!lease_active && out_valid && !out_lease))
    else $error("stop did not end the lease");
`endif

endmodule

>>> tb/sv/dual_wheel_speed_controller_top_tb.sv
// self-checking testbench for the dual wheel speed controller top level
module dual_wheel_speed_controller_top_tb;
  import dwsc_pkg::*;

  localparam int HALF_PERIOD   = 4;
  localparam int RESET_CYCLES  = 8;
  localparam int DRAIN_CYCLES  = 8;      // idle edges after the last pending status is taken
  localparam int HOLD_CYCLES   = 300;    // long receiver hold-off that fills the pipe
  localparam int SEGMENT_ITEMS = 325;
  localparam int SEGMENTS      = 6;
  localparam int CYCLE_LIMIT   = 400000;
  localparam int MAX_REPORTS   = 40;

  // result bus layout, lowest bit up
  localparam int DRV_L_LSB = 0;
  localparam int DRV_R_LSB = 17;
  localparam int LEASE_BIT = 34;
  localparam int ODO_L_LSB = 35;
  localparam int ODO_R_LSB = 67;

  // one command toward the controller, with an optional register write before it
  // and optional hand-typed result fields
  typedef struct {
    bit                 do_cfg;
    reg_index_t         cfg_reg;
    logic [31:0]        cfg_val;
    req_type_t          kind;
    logic signed [15:0] cnt_l;
    logic signed [15:0] cnt_r;
    logic signed [15:0] spd_l;
    logic signed [15:0] spd_r;
    bit                 typed;
    logic signed [16:0] drv_l;
    logic signed [16:0] drv_r;
    logic               ack;
    logic               lease;
  } speed_cmd_t;

  // one status transaction from the controller
  typedef struct {
    logic signed [16:0] drive_l;
    logic signed [16:0] drive_r;
    logic               ack;
    logic               lease;
    logic signed [31:0] odo_l;
    logic signed [31:0] odo_r;
  } wheel_status_t;

  // ---------------------------------------------------------------------------
  // clock, reset and dut
  // ---------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst = 1'b1;

  always #HALF_PERIOD clk = ~clk;

  logic         s_tvalid = 1'b0;
  logic         s_tready;
  logic [1:0]   s_tuser = REQ_TICK;
  logic [63:0]  s_tdata = '0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  logic         m_tuser;
  logic [103:0] m_tdata;
  logic         cfg_valid = 1'b0;
  logic         cfg_ready;
  logic [2:0]   cfg_index = REG_GAIN_P;
  logic [31:0]  cfg_data = '0;

  dual_wheel_speed_controller_top u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tuser   (s_tuser),   // req_type
    .s_tdata   (s_tdata),   // count_left, count_right, cmd_speed_l, cmd_speed_r
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tuser   (m_tuser),   // ack_code
    .m_tdata   (m_tdata),   // drive_left, drive_right, lease_on, odometer_left,
                            // odometer_right, zero fill
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  // ---------------------------------------------------------------------------
  // controller shadow: settings and motion state
  // ---------------------------------------------------------------------------
  logic [21:0]        cfg_kp;
  logic [15:0]        cfg_kd;
  logic [15:0]        cfg_dlim;
  logic [7:0]         cfg_step;
  logic [14:0]        cfg_slim;
  logic [15:0]        cfg_lease_len;

  logic signed [15:0] target_l, target_r;
  logic signed [15:0] ramp_l, ramp_r;
  logic signed [16:0] accum_l, accum_r;
  logic signed [17:0] prev_err_l, prev_err_r;
  logic signed [31:0] odo_l, odo_r;
  logic               lease_live;
  logic [15:0]        lease_elapsed;

  wheel_status_t pending_results[$];
  speed_cmd_t    offered;          // command currently on the input channel

  int tx_idle_pct  = 13;
  int rx_stall_pct = 81;
  int hold_requests = 0;

  int err_count       = 0;
  int items_sent      = 0;
  int results_checked = 0;
  int set_rejects     = 0;
  int lease_expiries  = 0;
  int active_controls = 0;
  int cycle_count     = 0;

  // stop: everything but the odometers goes back to zero
  function automatic void halt_motion();
    target_l = '0;    target_r = '0;
    ramp_l = '0;      ramp_r = '0;
    accum_l = '0;     accum_r = '0;
    prev_err_l = '0;  prev_err_r = '0;
    lease_live = 1'b0;
    lease_elapsed = '0;
  endfunction

  task automatic reset_shadow();
    cfg_kp = GAIN_P_RESET;
    cfg_kd = GAIN_D_RESET;
    cfg_dlim = DRIVE_LIMIT_RESET;
    cfg_step = SLEW_STEP_RESET;
    cfg_slim = SPEED_LIMIT_RESET;
    cfg_lease_len = LEASE_LENGTH_RESET;
    halt_motion();
    odo_l = '0;
    odo_r = '0;
  endtask

  function automatic logic signed [15:0] slew_ramp(logic signed [15:0] cur,
                                                   logic signed [15:0] tgt);
    int c, t, s;
    c = cur;
    t = tgt;
    s = cfg_step;
    if (c < t) begin
      c += s;
      if (c > t) c = t;
    end else if (c > t) begin
      c -= s;
      if (c < t) c = t;
    end
    return c[15:0];
  endfunction

  // incremental pd in q16, quotient truncated toward zero, then symmetric clamp
  function automatic logic signed [16:0] pd_accum(logic signed [16:0] acc,
                                                  logic signed [17:0] prev, longint err);
    longint sum, a, lim;
    sum = longint'(cfg_kp) * err + longint'(cfg_kd) * (err - longint'(prev));
    a = longint'(acc) + sum / 65536;
    lim = longint'(cfg_dlim);
    if (a > lim) a = lim;
    else if (a < -lim) a = -lim;
    return a[16:0];
  endfunction

  function automatic bit speed_fits(logic signed [15:0] s);
    int v, lim;
    v = s;
    lim = cfg_slim;
    return (v >= -lim) && (v <= lim);
  endfunction

  // advance the shadow by one accepted command and return its status
  function automatic wheel_status_t predict_wheel_step(speed_cmd_t c);
    wheel_status_t r;
    longint err_l, err_r;
    r.ack = ACK_OK;
    case (c.kind)
      REQ_TICK: begin
        if (lease_live) begin
          if (lease_elapsed != ELAPSED_MAX) lease_elapsed++;
          if (lease_elapsed >= cfg_lease_len) begin
            halt_motion();
            lease_expiries++;
          end
        end
      end
      REQ_SET: begin
        if (speed_fits(c.spd_l) && speed_fits(c.spd_r)) begin
          target_l = c.spd_l;
          target_r = c.spd_r;
          lease_elapsed = '0;
          lease_live = 1'b1;
        end else begin
          r.ack = ACK_REJECT;
          set_rejects++;
        end
      end
      REQ_STOP: halt_motion();
      default: begin
        odo_l += 32'(c.cnt_l);
        odo_r += 32'(c.cnt_r);
        ramp_l = slew_ramp(ramp_l, target_l);
        ramp_r = slew_ramp(ramp_r, target_r);
        if (lease_live) begin
          err_l = longint'(ramp_l) - longint'(c.cnt_l);
          err_r = longint'(ramp_r) - longint'(c.cnt_r);
          accum_l = pd_accum(accum_l, prev_err_l, err_l);
          accum_r = pd_accum(accum_r, prev_err_r, err_r);
          prev_err_l = err_l[17:0];
          prev_err_r = err_r[17:0];
          active_controls++;
        end
      end
    endcase
    r.drive_l = lease_live ? accum_l : '0;
    r.drive_r = lease_live ? accum_r : '0;
    r.lease = lease_live;
    r.odo_l = odo_l;
    r.odo_r = odo_r;
    return r;
  endfunction

  task automatic check_field(string what, longint want, longint got);
    if (want != got) begin
      err_count++;
      if (err_count <= MAX_REPORTS)
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, want, got);
    end
  endtask

  // ---------------------------------------------------------------------------
  // monitor: every handshake is sampled at the rising edge
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    wheel_status_t want;
    if (rst) begin
      reset_shadow();
    end else begin
      // register write transaction
      if (cfg_valid && cfg_ready) begin
        case (reg_index_t'(cfg_index))
          REG_GAIN_P:       cfg_kp = cfg_data[21:0];
          REG_GAIN_D:       cfg_kd = cfg_data[15:0];
          REG_DRIVE_LIMIT:  cfg_dlim = cfg_data[15:0];
          REG_SLEW_STEP:    cfg_step = cfg_data[7:0];
          REG_SPEED_LIMIT:  cfg_slim = cfg_data[14:0];
          REG_LEASE_LENGTH: cfg_lease_len = cfg_data[15:0];
          default: ;
        endcase
      end
      // command transaction: predict, with hand-typed fields taking over
      if (s_tvalid && s_tready) begin
        want = predict_wheel_step(offered);
        if (offered.typed) begin
          want.drive_l = offered.drv_l;
          want.drive_r = offered.drv_r;
          want.ack = offered.ack;
          want.lease = offered.lease;
        end
        pending_results.push_back(want);
        items_sent++;
      end
      // status transaction: compare with the oldest prediction
      if (m_tvalid && m_tready) begin
        if (pending_results.size() == 0) begin
          err_count++;
          $display("%0t: status transaction with nothing pending, expected none, actual %h",
                   $time, m_tdata);
        end else begin
          want = pending_results.pop_front();
          results_checked++;
          check_field("drive_left", want.drive_l, $signed(m_tdata[DRV_L_LSB +: 17]));
          check_field("drive_right", want.drive_r, $signed(m_tdata[DRV_R_LSB +: 17]));
          check_field("ack_code", want.ack, m_tuser);
          check_field("lease_on", want.lease, m_tdata[LEASE_BIT]);
          check_field("odometer_left", want.odo_l, $signed(m_tdata[ODO_L_LSB +: 32]));
          check_field("odometer_right", want.odo_r, $signed(m_tdata[ODO_R_LSB +: 32]));
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // receiver: random stalls, plus long hold-offs on request
  // ---------------------------------------------------------------------------
  int hold_served = 0;
  int hold_left = 0;

  always @(negedge clk) begin
    if (hold_served != hold_requests) begin
      hold_left = HOLD_CYCLES;
      hold_served++;
    end
    if (hold_left > 0) begin
      hold_left--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("%0t: run stalled with %0d status transactions pending",
               $time, pending_results.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // drivers
  // ---------------------------------------------------------------------------
  // offer one command, idling at random first; returns at the accepting edge
  task automatic send_item(speed_cmd_t c);
    @(negedge clk);
    while ($urandom_range(99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(negedge clk);
    end
    offered = c;
    s_tvalid <= 1'b1;
    s_tuser <= c.kind;
    s_tdata <= {c.spd_r, c.spd_l, c.cnt_r, c.cnt_l};
    do @(posedge clk); while (!s_tready);
  endtask

  // quiet the input and let every pending status come out
  task automatic wait_drained();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(reg_index_t idx, logic [31:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one full register setting per random segment, extremes included
  task automatic apply_settings(int mode);
    logic [31:0] kp_v, kd_v, lim_v, step_v, speed_v, lease_v;
    case (mode)
      0: begin
        kp_v = GAIN_P_RESET;        kd_v = GAIN_D_RESET;
        lim_v = DRIVE_LIMIT_RESET;  step_v = SLEW_STEP_RESET;
        speed_v = SPEED_LIMIT_RESET; lease_v = LEASE_LENGTH_RESET;
      end
      1: begin // short lease so expiry happens often
        kp_v = $urandom_range(1048575, 65536); kd_v = $urandom_range(4000);
        lim_v = $urandom_range(20000, 1000);   step_v = $urandom_range(40, 1);
        speed_v = $urandom_range(2000, 100);   lease_v = $urandom_range(12, 1);
      end
      2: begin // everything at its top
        kp_v = 32'd4194303; kd_v = 32'd65535; lim_v = 32'd65535;
        step_v = 32'd255;   speed_v = 32'd32767; lease_v = 32'd65535;
      end
      3: begin // no proportional term, tight clamp
        kp_v = '0;                            kd_v = $urandom_range(65535);
        lim_v = $urandom_range(500);          step_v = $urandom_range(255, 1);
        speed_v = $urandom_range(32767);      lease_v = $urandom_range(60, 5);
      end
      4: begin
        kp_v = $urandom_range(4194303);       kd_v = $urandom_range(65535);
        lim_v = $urandom_range(65535);        step_v = $urandom_range(255, 1);
        speed_v = $urandom_range(32767);      lease_v = $urandom_range(400, 1);
      end
      default: begin // only zero speeds pass, ramps barely move
        kp_v = $urandom_range(600000);        kd_v = '0;
        lim_v = $urandom_range(65535, 1);     step_v = $urandom_range(3);
        speed_v = '0;                         lease_v = $urandom_range(100, 20);
      end
    endcase
    write_reg(REG_GAIN_P, kp_v);
    write_reg(REG_GAIN_D, kd_v);
    write_reg(REG_DRIVE_LIMIT, lim_v);
    write_reg(REG_SLEW_STEP, step_v);
    write_reg(REG_SPEED_LIMIT, speed_v);
    write_reg(REG_LEASE_LENGTH, lease_v);
  endtask

  // ---------------------------------------------------------------------------
  // stimulus builders
  // ---------------------------------------------------------------------------
  function automatic speed_cmd_t make_cmd(req_type_t k, int cl, int cr, int sl, int sr);
    speed_cmd_t c;
    c.do_cfg = 1'b0;
    c.cfg_reg = REG_GAIN_P;
    c.cfg_val = '0;
    c.kind = k;
    c.cnt_l = cl[15:0];
    c.cnt_r = cr[15:0];
    c.spd_l = sl[15:0];
    c.spd_r = sr[15:0];
    c.typed = 1'b0;
    c.drv_l = '0;
    c.drv_r = '0;
    c.ack = ACK_OK;
    c.lease = 1'b0;
    return c;
  endfunction

  function automatic speed_cmd_t fixed_result(speed_cmd_t c, int dl, int dr,
                                              logic ack, logic lease);
    c.typed = 1'b1;
    c.drv_l = dl[16:0];
    c.drv_r = dr[16:0];
    c.ack = ack;
    c.lease = lease;
    return c;
  endfunction

  function automatic speed_cmd_t after_write(reg_index_t r, logic [31:0] v, speed_cmd_t c);
    c.do_cfg = 1'b1;
    c.cfg_reg = r;
    c.cfg_val = v;
    return c;
  endfunction

  // speed that the current limit accepts, or one just outside it
  function automatic logic signed [15:0] pick_speed(bit in_range);
    int lim, mag;
    lim = cfg_slim;
    if (in_range) return 16'($urandom_range(2 * lim) - lim);
    mag = $urandom_range(32768, lim + 1);
    if (mag == 32768) return 16'sh8000;
    return $urandom_range(1) ? 16'(-mag) : 16'(mag);
  endfunction

  // mostly commands and control periods that track the ramp, some noise
  function automatic speed_cmd_t random_cmd();
    speed_cmd_t c;
    int pick;
    c = make_cmd(REQ_TICK, $urandom, $urandom, $urandom, $urandom);
    pick = $urandom_range(99);
    if (pick < 12) begin
      c.kind = REQ_SET;
      if ($urandom_range(99) < 85) begin
        c.spd_l = pick_speed(1'b1);
        c.spd_r = pick_speed(1'b1);
      end else begin
        c.spd_l = pick_speed($urandom_range(1));
        c.spd_r = pick_speed(1'b0);
        if ($urandom_range(1)) {c.spd_l, c.spd_r} = {c.spd_r, c.spd_l};
      end
    end else if (pick < 50) begin
      c.kind = REQ_CONTROL;
      if ($urandom_range(99) < 85) begin
        c.cnt_l = 16'(int'(ramp_l) + int'($urandom_range(80)) - 40);
        c.cnt_r = 16'(int'(ramp_r) + int'($urandom_range(80)) - 40);
      end
    end else if (pick >= 96) begin
      c.kind = REQ_STOP;
    end
    return c;
  endfunction

  // ---------------------------------------------------------------------------
  // main sequence
  // ---------------------------------------------------------------------------
  initial begin
    speed_cmd_t directed[$];
    int directed_count;

    // reset defaults: limit 420, lease 300, step 20, kp 7.0, clamp 7199
    directed.push_back(fixed_result(make_cmd(REQ_TICK, 0, 0, 0, 0), 0, 0, ACK_OK, 1'b0));
    directed.push_back(fixed_result(make_cmd(REQ_CONTROL, 32767, -32768, 0, 0),
                                    0, 0, ACK_OK, 1'b0));
    directed.push_back(fixed_result(make_cmd(REQ_SET, 0, 0, 421, 0), 0, 0, ACK_REJECT, 1'b0));
    directed.push_back(fixed_result(make_cmd(REQ_SET, 0, 0, 0, -421), 0, 0, ACK_REJECT, 1'b0));
    directed.push_back(fixed_result(make_cmd(REQ_SET, -1, -1, -32768, 32767),
                                    0, 0, ACK_REJECT, 1'b0));
    directed.push_back(fixed_result(make_cmd(REQ_SET, 0, 0, 420, -420), 0, 0, ACK_OK, 1'b1));
    directed.push_back(make_cmd(REQ_CONTROL, 0, 0, 0, 0));
    // counts at the extremes drive both wheels into the clamp
    directed.push_back(fixed_result(make_cmd(REQ_CONTROL, 32767, -32768, 0, 0),
                                    -7199, 7199, ACK_OK, 1'b1));
    // new set point while active keeps the accumulated drive
    directed.push_back(fixed_result(make_cmd(REQ_SET, 0, 0, 100, 100),
                                    -7199, 7199, ACK_OK, 1'b1));
    directed.push_back(make_cmd(REQ_CONTROL, 5, -5, 0, 0));
    directed.push_back(make_cmd(REQ_TICK, 0, 0, 0, 0));
    directed.push_back(fixed_result(make_cmd(REQ_STOP, 0, 0, 0, 0), 0, 0, ACK_OK, 1'b0));
    // zero lease length runs out on the very first tick
    directed.push_back(after_write(REG_LEASE_LENGTH, '0,
      fixed_result(make_cmd(REQ_SET, 0, 0, 10, -10), 0, 0, ACK_OK, 1'b1)));
    directed.push_back(fixed_result(make_cmd(REQ_TICK, 0, 0, 0, 0), 0, 0, ACK_OK, 1'b0));
    // zero slew step holds the ramps where they are
    directed.push_back(after_write(REG_SLEW_STEP, '0,
      fixed_result(make_cmd(REQ_SET, 0, 0, 300, 300), 0, 0, ACK_OK, 1'b1)));
    directed.push_back(fixed_result(make_cmd(REQ_CONTROL, 0, 0, 0, 0), 0, 0, ACK_OK, 1'b1));
    // two-tick lease with the widest step
    directed.push_back(after_write(REG_LEASE_LENGTH, 32'd2,
      fixed_result(make_cmd(REQ_TICK, 0, 0, 0, 0), 0, 0, ACK_OK, 1'b1)));
    directed.push_back(after_write(REG_SLEW_STEP, 32'd255,
      make_cmd(REQ_CONTROL, -32768, 32767, 0, 0)));
    directed.push_back(fixed_result(make_cmd(REQ_TICK, 0, 0, 0, 0), 0, 0, ACK_OK, 1'b0));
    // clamp of zero pins the drive at zero
    directed.push_back(after_write(REG_DRIVE_LIMIT, '0,
      fixed_result(make_cmd(REQ_SET, 0, 0, 1, 1), 0, 0, ACK_OK, 1'b1)));
    directed.push_back(fixed_result(make_cmd(REQ_CONTROL, 32767, -32768, 0, 0),
                                    0, 0, ACK_OK, 1'b1));
    // widest speed, clamp and gains
    directed.push_back(after_write(REG_SPEED_LIMIT, 32'd32767,
      fixed_result(make_cmd(REQ_SET, 0, 0, 32767, -32767), 0, 0, ACK_OK, 1'b1)));
    directed.push_back(after_write(REG_DRIVE_LIMIT, 32'd65535,
      fixed_result(make_cmd(REQ_TICK, 0, 0, 0, 0), 0, 0, ACK_OK, 1'b1)));
    directed.push_back(after_write(REG_GAIN_P, 32'd4194303,
      fixed_result(make_cmd(REQ_CONTROL, -32768, 32767, 0, 0), 65535, -65535, ACK_OK, 1'b1)));
    // most negative speed never fits, even with the widest limit
    directed.push_back(after_write(REG_GAIN_D, 32'd65535,
      fixed_result(make_cmd(REQ_SET, 0, 0, -32768, 0), 65535, -65535, ACK_REJECT, 1'b1)));
    directed_count = directed.size();

    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    foreach (directed[i]) begin
      if (directed[i].do_cfg) begin
        wait_drained();
        write_reg(directed[i].cfg_reg, directed[i].cfg_val);
      end
      send_item(directed[i]);
    end

    // random segments: sparse receiver first, then sparse sender, then full rate
    for (int seg = 0; seg < SEGMENTS; seg++) begin
      wait_drained();
      if (seg == 2) begin
        tx_idle_pct = 81;
        rx_stall_pct = 13;
      end else if (seg == 4) begin
        tx_idle_pct = 0;
        rx_stall_pct = 0;
      end
      apply_settings(seg);
      // receiver holds off while the sender keeps pushing at full rate
      if (seg == 4) hold_requests++;
      repeat (SEGMENT_ITEMS) send_item(random_cmd());
    end

    wait_drained();

    $display("covered %0d command transactions (%0d directed) and %0d status checks",
             items_sent, directed_count, results_checked);
    $display("over six register settings: %0d rejected set points, %0d lease expiries,",
             set_rejects, lease_expiries);
    $display("and %0d control periods under an active lease", active_controls);
    if (err_count == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
design/dwsc_pkg.sv
design/dwsc_wheel.sv
design/dual_wheel_speed_controller_top.sv
tb/sv/dual_wheel_speed_controller_top_tb.sv
